// ----- rtl/sorted_event_timer_queue_macros.svh -----
// Assertion macros for the sorted event timer queue.
// Used by the top level; the bodies are empty when SYNTHESIS is defined.
`ifndef SORTED_EVENT_TIMER_QUEUE_MACROS_SVH
`define SORTED_EVENT_TIMER_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define SETQ_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sorted timer queue check failed");
// Next-cycle implication check.
`define SETQ_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sorted timer queue check failed");
`else
`define SETQ_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define SETQ_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ----- rtl/setq_pkg.sv -----
// Package for the sorted event timer queue: sizes, request codes, states
// and the timer table write command. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package setq_pkg;
  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 32;
  localparam int ID_W       = 4;
  localparam int CNT_W      = 5;
  localparam int AW         = TIME_BITS + 1;

  typedef enum logic [2:0] {
    REQ_SET        = 3'd0,
    REQ_RESET      = 3'd1,
    REQ_RESET_NEXT = 3'd2,
    REQ_RESTART    = 3'd3,
    REQ_ADJUST     = 3'd4,
    REQ_STOP       = 3'd5,
    REQ_OWNER_EXIT = 3'd6,
    REQ_POLL       = 3'd7
  } req_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_DIV, ST_DIV_FIN, ST_UNL, ST_REM_SH, ST_AFTER_UNL,
    ST_INS_RD, ST_INS_CMP, ST_INS_SH, ST_REFRESH, ST_SUM, ST_SUM_OUT,
    ST_POLL_HEAD, ST_POLL_CMP, ST_FIRE_OUT, ST_OX_RD
  } state_t;

  // One write to the timer table; each field has its own enable.
  typedef struct packed {
    logic [ID_W-1:0]      idx;
    logic                 we_start;
    logic [TIME_BITS-1:0] start;
    logic                 we_period;
    logic [TIME_BITS-1:0] period;
    logic                 we_owner;
    logic [ID_W-1:0]      owner;
    logic                 we_on;
    logic                 on;
  } twr_t;

  // One entry read from the timer table.
  typedef struct packed {
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS-1:0] period;
    logic [ID_W-1:0]      owner;
    logic                 on;
  } trd_t;
endpackage
`default_nettype wire

// ----- rtl/setq_alu.sv -----
// Shared add/subtract unit of the timer queue sequencer.
// Depends on setq_pkg for the operand width.
`timescale 1ns / 1ps
`default_nettype none
module setq_alu
  import setq_pkg::*;
(
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  input  logic          sub,
  output logic [AW-1:0] res
);
  // Subtraction is addition of the complement with a carry in.
  logic [AW-1:0] b_op;
  assign b_op = sub ? ~b : b;
  assign res  = a + b_op + AW'(sub);
endmodule
`default_nettype wire

// ----- rtl/setq_table.sv -----
// Timer entry table: start, period, owner and on-list bit for each timer.
// Depends on setq_pkg; one read port and one write command per cycle.
`timescale 1ns / 1ps
`default_nettype none
module setq_table
  import setq_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  twr_t            wr,
  input  logic [ID_W-1:0] rd_idx,
  output trd_t            rd
);
  logic [TIME_BITS-1:0] start_time [NUM_TIMERS];
  logic [TIME_BITS-1:0] period     [NUM_TIMERS];
  logic [ID_W-1:0]      owner      [NUM_TIMERS];
  logic                 on_list    [NUM_TIMERS];

  // All entries clear together at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        start_time[i] <= '0;
        period[i]     <= '0;
        owner[i]      <= '0;
        on_list[i]    <= 1'b0;
      end
    end else begin
      if (wr.we_start)  start_time[wr.idx] <= wr.start;
      if (wr.we_period) period[wr.idx]     <= wr.period;
      if (wr.we_owner)  owner[wr.idx]      <= wr.owner;
      if (wr.we_on)     on_list[wr.idx]    <= wr.on;
    end
  end

  // Single read port.
  assign rd.start  = start_time[rd_idx];
  assign rd.period = period[rd_idx];
  assign rd.owner  = owner[rd_idx];
  assign rd.on     = on_list[rd_idx];
endmodule
`default_nettype wire

// ----- rtl/sorted_event_timer_queue.sv -----
// Sorted event timer queue: a sequencer walks the sorted list one entry at a time.
// Each request ends in a summary; the time grows with each list entry scanned, compared or
// shifted, reset_next first runs a bitwise restoring remainder, and each fired timer is
// output and unlinked before the summary.
// One request at a time; ready returns the cycle after the summary transfer.
// Reset (rst, synchronous): all timer entries clear, the list empties, next expiry 0.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_event_timer_queue_macros.svh"
module sorted_event_timer_queue
  import setq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // req_type[2:0], timer_id[6:3], owner_id[10:7], interval_in[42:11],
  // time_diff[74:43], now_time[106:75]
  input  logic [111:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // fired_timer[3:0], fired_owner[7:4], addr_expired[8], addr_expiry_time[40:9],
  // addr_start_time[72:41], any_pending[73], next_expiry[105:74]
  output logic [111:0] m_tdata,
  // result_kind
  output logic         m_tuser,
  output logic         m_tlast
);
  state_t state, state_next, ret, ret_next;

  // Request registers.
  req_t                 r_req;
  logic [ID_W-1:0]      r_id, r_who;
  logic [TIME_BITS-1:0] r_iv, r_diff, r_now;

  // Sequencer registers.
  logic [CNT_W-1:0]     k, k_next, k_save, k_save_next, j, j_next, count, count_next;
  logic [ID_W-1:0]      rem_id, rem_id_next;
  logic [TIME_BITS-1:0] acc, acc_next, tmp, tmp_next, rem, rem_next;
  logic [TIME_BITS-1:0] head_exp, head_exp_next;
  logic [CNT_W-1:0]     bitc, bitc_next;

  // Output register.
  logic                 o_kind, o_kind_next, o_ae, o_ae_next, o_ap, o_ap_next;
  logic                 o_last, o_last_next;
  logic [ID_W-1:0]      o_ft, o_ft_next, o_fo, o_fo_next;
  logic [TIME_BITS-1:0] o_aet, o_aet_next, o_ast, o_ast_next, o_ne, o_ne_next;

  // Sorted id list, one read and one write per cycle.
  logic [ID_W-1:0]  sorted [NUM_TIMERS];
  logic [CNT_W-1:0] sidx;
  logic [ID_W-1:0]  sorted_rd;
  logic             s_we;
  logic [ID_W-1:0]  s_widx, s_wdata;

  logic [ID_W-1:0] tsel;
  trd_t            t_rd;
  twr_t            tw;
  logic [AW-1:0]   alu_a, alu_b, alu_res;
  logic            alu_sub;

  logic k_end, id_ok, arm_req;

  assign sorted_rd = sorted[sidx[ID_W-1:0]];
  assign k_end     = (k == count);
  assign id_ok     = ({1'b0, r_id} < CNT_W'(NUM_TIMERS));
  assign arm_req   = (r_req != REQ_OWNER_EXIT) && (r_req != REQ_POLL);

  setq_table u_table (
    .clk    (clk),
    .rst    (rst),
    .wr     (tw),
    .rd_idx (tsel),
    .rd     (t_rd)
  );

  setq_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_DECODE;
      ST_DECODE: begin
        priority if (r_req == REQ_OWNER_EXIT) state_next = ST_OX_RD;
        else if (r_req == REQ_POLL)           state_next = ST_POLL_HEAD;
        else if (!id_ok)                      state_next = ST_SUM;
        else if (r_req == REQ_RESET_NEXT && t_rd.period != '0) state_next = ST_DIV;
        else                                  state_next = ST_UNL;
      end
      ST_DIV:       if (bitc == '0) state_next = ST_DIV_FIN;
      ST_DIV_FIN:   state_next = ST_UNL;
      ST_UNL: begin
        priority if (!t_rd.on || k_end) state_next = ST_AFTER_UNL;
        else if (sorted_rd == r_id)     state_next = ST_REM_SH;
        else                            state_next = ST_UNL;
      end
      ST_REM_SH:    if ((k + CNT_W'(1)) >= count) state_next = ret;
      ST_AFTER_UNL: state_next = (r_req == REQ_STOP) ? ST_SUM : ST_INS_RD;
      ST_INS_RD:    state_next = k_end ? ST_INS_SH : ST_INS_CMP;
      ST_INS_CMP:   state_next = alu_res[TIME_BITS-1] ? ST_INS_SH : ST_INS_RD;
      ST_INS_SH:    if (j == k) state_next = ST_REFRESH;
      ST_REFRESH:   state_next = ST_SUM;
      ST_SUM:       state_next = ST_SUM_OUT;
      ST_SUM_OUT:   if (m_tready) state_next = ST_IDLE;
      ST_POLL_HEAD: state_next = (count == '0) ? ST_REFRESH : ST_POLL_CMP;
      ST_POLL_CMP:  state_next = alu_res[TIME_BITS] ? ST_REFRESH : ST_FIRE_OUT;
      ST_FIRE_OUT:  if (m_tready) state_next = ST_REM_SH;
      ST_OX_RD: begin
        priority if (k_end)            state_next = ST_REFRESH;
        else if (t_rd.owner == r_who)  state_next = ST_REM_SH;
        else                           state_next = ST_OX_RD;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Datapath control and register next values.
  always_comb begin
    ret_next = ret;  k_next = k;  k_save_next = k_save;  j_next = j;
    count_next = count;  rem_id_next = rem_id;  acc_next = acc;  tmp_next = tmp;
    rem_next = rem;  head_exp_next = head_exp;  bitc_next = bitc;
    o_kind_next = o_kind;  o_ae_next = o_ae;  o_ap_next = o_ap;  o_last_next = o_last;
    o_ft_next = o_ft;  o_fo_next = o_fo;  o_aet_next = o_aet;  o_ast_next = o_ast;
    o_ne_next = o_ne;
    sidx = k;  tsel = r_id;  tw = '0;  tw.idx = r_id;
    alu_a = '0;  alu_b = '0;  alu_sub = 1'b0;
    s_we = 1'b0;  s_widx = '0;  s_wdata = '0;
    unique case (state)
      ST_DECODE: begin
        k_next = '0;
        if (id_ok && arm_req) begin
          unique case (r_req)
            REQ_SET: begin
              tw.we_start = 1'b1;  tw.start = r_now;
              tw.we_period = 1'b1; tw.period = r_iv;
            end
            REQ_RESTART: begin
              tw.we_start = 1'b1;  tw.start = r_now;
            end
            REQ_RESET: begin
              alu_a = {1'b0, t_rd.start};  alu_b = {1'b0, t_rd.period};
              tw.we_start = 1'b1;  tw.start = alu_res[TIME_BITS-1:0];
            end
            REQ_ADJUST: begin
              alu_a = {1'b0, t_rd.start};  alu_b = {1'b0, r_diff};
              tw.we_start = 1'b1;  tw.start = alu_res[TIME_BITS-1:0];
            end
            REQ_RESET_NEXT: begin
              if (t_rd.period == '0) begin
                tw.we_start = 1'b1;  tw.start = r_now;
              end else begin
                // Elapsed time, then its remainder by the period.
                alu_a = {1'b0, r_now};  alu_b = {1'b0, t_rd.start};  alu_sub = 1'b1;
                acc_next  = alu_res[TIME_BITS-1:0];
                rem_next  = '0;
                bitc_next = CNT_W'(TIME_BITS - 1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        // One restoring remainder step.
        alu_a = {rem, acc[TIME_BITS-1]};  alu_b = {1'b0, t_rd.period};  alu_sub = 1'b1;
        rem_next  = alu_res[TIME_BITS] ? {rem[TIME_BITS-2:0], acc[TIME_BITS-1]}
                                       : alu_res[TIME_BITS-1:0];
        acc_next  = {acc[TIME_BITS-2:0], 1'b0};
        bitc_next = bitc - CNT_W'(1);
      end
      ST_DIV_FIN: begin
        // New start is now less the remainder.
        alu_a = {1'b0, r_now};  alu_b = {1'b0, rem};  alu_sub = 1'b1;
        tw.we_start = 1'b1;  tw.start = alu_res[TIME_BITS-1:0];
      end
      ST_UNL: begin
        if (t_rd.on) begin
          priority if (k_end) begin
            tw.we_on = 1'b1;  tw.on = 1'b0;
          end else if (sorted_rd == r_id) begin
            rem_id_next = r_id;  k_save_next = k;  ret_next = ST_AFTER_UNL;
          end else begin
            k_next = k + CNT_W'(1);
          end
        end
      end
      ST_REM_SH: begin
        // Close the gap left by the removed entry.
        sidx = k + CNT_W'(1);
        if ((k + CNT_W'(1)) < count) begin
          s_we = 1'b1;  s_widx = k[ID_W-1:0];  s_wdata = sorted_rd;
          k_next = k + CNT_W'(1);
        end else begin
          count_next = count - CNT_W'(1);
          tw.idx = rem_id;  tw.we_on = 1'b1;  tw.on = 1'b0;
          k_next = k_save;
        end
      end
      ST_AFTER_UNL: begin
        if (r_req == REQ_STOP) begin
          tw.we_owner = 1'b1;  tw.owner = '0;
        end else begin
          alu_a = {1'b0, t_rd.start};  alu_b = {1'b0, t_rd.period};
          acc_next = alu_res[TIME_BITS-1:0];
          k_next = '0;
        end
      end
      ST_INS_RD: begin
        tsel = sorted_rd;
        if (k_end) begin
          j_next = count;
        end else begin
          alu_a = {1'b0, t_rd.start};  alu_b = {1'b0, t_rd.period};
          tmp_next = alu_res[TIME_BITS-1:0];
        end
      end
      ST_INS_CMP: begin
        // New timer goes before the first entry that expires strictly later.
        alu_a = {1'b0, acc};  alu_b = {1'b0, tmp};  alu_sub = 1'b1;
        if (alu_res[TIME_BITS-1]) j_next = count;
        else                      k_next = k + CNT_W'(1);
      end
      ST_INS_SH: begin
        sidx = j - CNT_W'(1);
        if (j != k) begin
          s_we = 1'b1;  s_widx = j[ID_W-1:0];  s_wdata = sorted_rd;
          j_next = j - CNT_W'(1);
        end else begin
          s_we = 1'b1;  s_widx = k[ID_W-1:0];  s_wdata = r_id;
          count_next = count + CNT_W'(1);
          tw.we_on = 1'b1;  tw.on = 1'b1;
          tw.we_owner = 1'b1;  tw.owner = r_who;
        end
      end
      ST_REFRESH: begin
        sidx = '0;  tsel = sorted_rd;
        alu_a = {1'b0, t_rd.start};  alu_b = {1'b0, t_rd.period};
        head_exp_next = (count == '0) ? '0 : alu_res[TIME_BITS-1:0];
      end
      ST_SUM: begin
        alu_a = {1'b0, t_rd.start};  alu_b = {1'b0, t_rd.period};
        o_kind_next = 1'b0;  o_ft_next = '0;  o_fo_next = '0;  o_last_next = 1'b1;
        o_ae_next  = id_ok ? (t_rd.owner == '0) : 1'b1;
        o_aet_next = id_ok ? alu_res[TIME_BITS-1:0] : '0;
        o_ast_next = id_ok ? t_rd.start : '0;
        o_ap_next  = (count != '0);
        o_ne_next  = (count != '0) ? head_exp : '0;
      end
      ST_POLL_HEAD: begin
        sidx = '0;  tsel = sorted_rd;
        alu_a = {1'b0, r_now};  alu_b = {1'b0, t_rd.start};  alu_sub = 1'b1;
        acc_next = alu_res[TIME_BITS-1:0];
      end
      ST_POLL_CMP: begin
        // Head is expired when elapsed time is not below its period.
        sidx = '0;  tsel = sorted_rd;
        alu_a = {1'b0, acc};  alu_b = {1'b0, t_rd.period};  alu_sub = 1'b1;
        if (!alu_res[TIME_BITS]) begin
          o_kind_next = 1'b1;  o_ft_next = sorted_rd;  o_fo_next = t_rd.owner;
          o_ae_next = 1'b0;  o_aet_next = '0;  o_ast_next = '0;  o_ap_next = 1'b0;
          o_ne_next = '0;  o_last_next = 1'b0;
          rem_id_next = sorted_rd;  k_next = '0;  k_save_next = '0;
          ret_next = ST_POLL_HEAD;
        end
      end
      ST_FIRE_OUT: begin
        if (m_tready) begin
          tw.idx = rem_id;  tw.we_owner = 1'b1;  tw.owner = '0;
        end
      end
      ST_OX_RD: begin
        tsel = sorted_rd;
        if (!k_end && t_rd.owner == r_who) begin
          rem_id_next = sorted_rd;  k_save_next = k;  ret_next = ST_OX_RD;
        end else if (!k_end) begin
          k_next = k + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_SUM_OUT) || (state == ST_FIRE_OUT);
  end

  assign m_tdata = {6'd0, o_ne, o_ap, o_ast, o_aet, o_ae, o_fo, o_ft};
  assign m_tuser = o_kind;
  assign m_tlast = o_last;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ret      <= ST_IDLE;
      count    <= '0;
      head_exp <= '0;
      k        <= '0;
      k_save   <= '0;
      j        <= '0;
      bitc     <= '0;
    end else begin
      state    <= state_next;
      ret      <= ret_next;
      count    <= count_next;
      head_exp <= head_exp_next;
      k        <= k_next;
      k_save   <= k_save_next;
      j        <= j_next;
      bitc     <= bitc_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      r_req  <= req_t'(s_tdata[2:0]);
      r_id   <= s_tdata[6:3];
      r_who  <= s_tdata[10:7];
      r_iv   <= s_tdata[42:11];
      r_diff <= s_tdata[74:43];
      r_now  <= s_tdata[106:75];
    end
    rem_id <= rem_id_next;
    acc    <= acc_next;
    tmp    <= tmp_next;
    rem    <= rem_next;
    o_kind <= o_kind_next;
    o_ft   <= o_ft_next;
    o_fo   <= o_fo_next;
    o_ae   <= o_ae_next;
    o_aet  <= o_aet_next;
    o_ast  <= o_ast_next;
    o_ap   <= o_ap_next;
    o_ne   <= o_ne_next;
    o_last <= o_last_next;
    if (s_we) sorted[s_widx] <= s_wdata;
  end

  // Checks on the sequencer.
  `SETQ_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CNT_W'(NUM_TIMERS))
  `SETQ_ASSERT_IMP(a_no_accept_while_out, clk, rst, s_tready, !m_tvalid)
  `SETQ_ASSERT_IMP(a_fired_not_last, clk, rst, state == ST_FIRE_OUT, m_tuser && !m_tlast)
  `SETQ_ASSERT_NXT(a_fired_then_unlink, clk, rst, state == ST_FIRE_OUT && m_tready,
    state == ST_REM_SH)
endmodule
`default_nettype wire

// ----- bench/timer_queue_checker.sv -----
// Checker for the sorted event timer queue: watches both streams, predicts the
// results of each accepted request and compares them. Depends on setq_pkg.
`timescale 1ns / 1ps
module timer_queue_checker
  import setq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [111:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,
  input  logic         m_tuser,
  input  logic         m_tlast,
  output int           fail_count,
  output int           pending_results
);

  typedef struct packed {
    logic        kind;
    logic [3:0]  ftimer;
    logic [3:0]  fowner;
    logic        aexp;
    logic [31:0] aexpiry;
    logic [31:0] astart;
    logic        anyp;
    logic [31:0] nexp;
    logic        lst;
  } timer_result_t;

  // Predicted timer table and sorted list.
  logic [31:0] t_start [NUM_TIMERS];
  logic [31:0] t_period[NUM_TIMERS];
  logic [3:0]  t_owner [NUM_TIMERS];
  logic        t_on    [NUM_TIMERS];
  int          order_q[$];
  logic [31:0] head_exp;
  timer_result_t awaited_q[$];

  assign pending_results = awaited_q.size();

  function automatic logic [31:0] expiry(int i);
    return t_start[i] + t_period[i];
  endfunction

  function automatic void unlink(int i);
    for (int k = 0; k < order_q.size(); k++)
      if (order_q[k] == i) begin
        order_q.delete(k);
        break;
      end
    t_on[i] = 0;
  endfunction

  function automatic void refresh_next();
    head_exp = order_q.size() ? expiry(order_q[0]) : 32'd0;
  endfunction

  function automatic void arm(int i, logic [3:0] who);
    logic [31:0] e;
    logic [31:0] dif;
    int pos;
    unlink(i);
    e = expiry(i);
    pos = order_q.size();
    for (int k = 0; k < order_q.size(); k++) begin
      dif = e - expiry(order_q[k]);
      if (dif[31]) begin
        pos = k;
        break;
      end
    end
    order_q.insert(pos, i);
    t_on[i] = 1;
    t_owner[i] = who;
    refresh_next();
  endfunction

  function automatic void predict_request(logic [111:0] d);
    req_t        rq;
    int          id;
    logic [3:0]  who;
    logic [31:0] iv, dt, now, el;
    timer_result_t r;
    int k;
    rq  = req_t'(d[2:0]);
    id  = int'(d[6:3]);
    who = d[10:7];
    iv  = d[42:11];
    dt  = d[74:43];
    now = d[106:75];
    case (rq)
      REQ_OWNER_EXIT: begin
        k = 0;
        while (k < order_q.size()) begin
          if (t_owner[order_q[k]] == who) begin
            t_on[order_q[k]] = 0;
            order_q.delete(k);
          end else k++;
        end
        refresh_next();
      end
      REQ_POLL: begin
        while (order_q.size() && (now - t_start[order_q[0]]) >= t_period[order_q[0]]) begin
          r = '0;
          r.kind = 1;
          r.ftimer = 4'(order_q[0]);
          r.fowner = t_owner[order_q[0]];
          awaited_q.push_back(r);
          t_owner[order_q[0]] = 0;
          t_on[order_q[0]] = 0;
          void'(order_q.pop_front());
        end
        refresh_next();
      end
      REQ_SET: begin
        t_start[id] = now;
        t_period[id] = iv;
        arm(id, who);
      end
      REQ_RESET: begin
        t_start[id] = expiry(id);
        arm(id, who);
      end
      REQ_RESET_NEXT: begin
        if (t_period[id] == 0) t_start[id] = now;
        else begin
          el = now - t_start[id];
          t_start[id] = t_start[id] + (el / t_period[id]) * t_period[id];
        end
        arm(id, who);
      end
      REQ_RESTART: begin
        t_start[id] = now;
        arm(id, who);
      end
      REQ_ADJUST: begin
        t_start[id] = t_start[id] + dt;
        arm(id, who);
      end
      default: begin
        unlink(id);
        t_owner[id] = 0;
      end
    endcase
    // Summary of the addressed timer always closes the request.
    r = '0;
    r.aexp = (t_owner[id] == 0);
    r.aexpiry = expiry(id);
    r.astart = t_start[id];
    r.anyp = order_q.size() != 0;
    r.nexp = order_q.size() ? head_exp : 32'd0;
    r.lst = 1;
    awaited_q.push_back(r);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    timer_result_t w;
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        t_start[i] = 0;
        t_period[i] = 0;
        t_owner[i] = 0;
        t_on[i] = 0;
      end
      order_q.delete();
      head_exp = 0;
      awaited_q.delete();
    end else begin
      // Result transfer first: a request accepted this edge cannot finish at it.
      if (m_tvalid && m_tready) begin
        if (awaited_q.size() == 0) report_mismatch("unexpected result", m_tdata[31:0], 0);
        else begin
          w = awaited_q.pop_front();
          if (m_tuser != w.kind) report_mismatch("result_kind", m_tuser, w.kind);
          if (m_tdata[3:0] != w.ftimer) report_mismatch("fired_timer", m_tdata[3:0], w.ftimer);
          if (m_tdata[7:4] != w.fowner) report_mismatch("fired_owner", m_tdata[7:4], w.fowner);
          if (m_tdata[8] != w.aexp) report_mismatch("addr_expired", m_tdata[8], w.aexp);
          if (m_tdata[40:9] != w.aexpiry)
            report_mismatch("addr_expiry_time", m_tdata[40:9], w.aexpiry);
          if (m_tdata[72:41] != w.astart)
            report_mismatch("addr_start_time", m_tdata[72:41], w.astart);
          if (m_tdata[73] != w.anyp) report_mismatch("any_pending", m_tdata[73], w.anyp);
          if (m_tdata[105:74] != w.nexp)
            report_mismatch("next_expiry", m_tdata[105:74], w.nexp);
          if (m_tlast != w.lst) report_mismatch("last", m_tlast, w.lst);
        end
      end
      if (s_tvalid && s_tready) predict_request(s_tdata);
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the sorted event timer queue: clock, reset, request
// stimulus with bursty sending and a stalling receiver. Uses timer_queue_checker.
`timescale 1ns / 1ps
module tb_top;
  import setq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [111:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;
  int           fail_count;
  int           pending_results;
  int           cycles = 0;
  logic [31:0]  clock_now = 32'd1000;

  always #5 clk = ~clk;

  sorted_event_timer_queue DUT (.*);

  timer_queue_checker chk (.*);

  // Receiver stall pattern: long ready runs mixed with random stalls.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if ((cycles / 300) % 3 == 0) m_tready <= 1;
    else m_tready <= ($urandom_range(0, 3) != 0);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  // Send one request and hold it until the block takes it.
  task automatic send_request(req_t rq, logic [3:0] id, logic [3:0] who,
                              logic [31:0] iv, logic [31:0] dt, logic [31:0] now);
    s_tdata  <= {5'd0, now, dt, iv, who, id, rq};
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic idle_gap();
    s_tvalid <= 0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Random request, mostly on a small clock range so that timers really fire.
  task automatic random_request();
    req_t rq;
    logic [31:0] iv, dt;
    int sel;
    sel = $urandom_range(0, 9);
    rq = req_t'($urandom_range(0, 7));
    iv = (sel == 0) ? $urandom : $urandom_range(0, 60);
    dt = (sel == 1) ? $urandom : $urandom_range(0, 40) - 20;
    clock_now = (sel == 2) ? $urandom : clock_now + $urandom_range(0, 25);
    send_request(rq, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), iv, dt,
                 clock_now);
  endtask

  initial begin
    int burst;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: field extremes, every request, owner zero, wrap and poll.
    send_request(REQ_POLL, 0, 1, 0, 0, 0);
    send_request(REQ_SET, 0, 1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    send_request(REQ_SET, 15, 15, 0, 0, 32'd5);
    send_request(REQ_SET, 3, 0, 32'd10, 0, 32'd5);
    send_request(REQ_SET, 4, 2, 32'd10, 0, 32'd5);
    send_request(REQ_RESET, 4, 2, 0, 0, 0);
    send_request(REQ_RESET_NEXT, 3, 3, 0, 0, 32'd47);
    send_request(REQ_SET, 5, 4, 0, 0, 32'd7);
    send_request(REQ_RESET_NEXT, 5, 4, 0, 0, 32'd9);
    send_request(REQ_RESTART, 15, 5, 0, 0, 32'hFFFF_FFF0);
    send_request(REQ_ADJUST, 4, 2, 0, 32'h8000_0000, 0);
    send_request(REQ_ADJUST, 4, 2, 0, 32'h7FFF_FFFF, 0);
    send_request(REQ_ADJUST, 3, 3, 0, 32'hFFFF_FFFF, 0);
    send_request(REQ_STOP, 5, 4, 0, 0, 0);
    send_request(REQ_STOP, 9, 1, 0, 0, 0);
    send_request(REQ_OWNER_EXIT, 0, 2, 0, 0, 0);
    send_request(REQ_POLL, 0, 1, 0, 0, 32'd100);
    send_request(REQ_OWNER_EXIT, 7, 15, 0, 0, 0);
    send_request(REQ_POLL, 1, 1, 0, 0, 32'hFFFF_FFFF);
    drain();
    // Random: bursts with gaps, and a full drain after each burst that starts at request 71 to 81.
    for (int n = 0; n < 160; n += burst) begin
      burst = $urandom_range(1, 10);
      for (int b = 0; b < burst; b++) random_request();
      if (n > 70 && n < 82) drain();
      else idle_gap();
    end
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
